// ===== hdl/tsd_pkg.sv =====
package tsd_pkg;

    // Field widths.
    localparam int DATA_W    = 32;
    localparam int PHYS_W    = 29;
    localparam int HITS_W    = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [PHYS_W-1:0] t_phys;
    typedef logic [HITS_W-1:0] t_hits;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Hit count at which a tracker counts as a stream.
    localparam t_hits HITS_MAX = 2'd2;
    localparam t_hits HITS_ONE = 2'd1;
    localparam t_hits HITS_EMPTY = 2'd0;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_LOW_DEST    = 3'd0;
    localparam t_cfg_idx CFG_MATCH_SIZE  = 3'd1;
    localparam t_cfg_idx CFG_WINDOW_LOW  = 3'd2;
    localparam t_cfg_idx CFG_WINDOW_HIGH = 3'd3;

    // Configuration reset values.
    localparam logic  RST_LOW_DEST    = 1'b0;
    localparam t_data RST_MATCH_SIZE  = 32'd1024;
    localparam t_phys RST_WINDOW_LOW  = 29'h0c20_0000;
    localparam t_phys RST_WINDOW_HIGH = 29'h0d00_0000;

endpackage

// ===== hdl/transfer_stream_detector_top.sv =====
// Sequence: after a transfer is accepted, a check step filters it; a request that passes
// scans one tracker entry per cycle through the single entry comparator and the one read
// port of the tracker memory, a fill step writes an entry on a miss, and the done step
// presents the result once the output register is free.
// Requests: one at a time; the next is taken once the result is in the output register.
// Reset (synchronous): control, hit counters and configuration registers reset; no sweep.
module transfer_stream_detector_top #(
    parameter int ENTRIES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port.
    input  logic                      i_cfg_we,
    input  tsd_pkg::t_cfg_idx         i_cfg_index,
    input  tsd_pkg::t_data            i_cfg_data,
    // Request channel.
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  tsd_pkg::t_data            i_dest_addr,
    input  tsd_pkg::t_data            i_transfer_size,
    input  tsd_pkg::t_data            i_read_offset,
    // Result channel.
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_is_stream
);
    import tsd_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Configuration registers.
    logic  r_low_dest;
    t_data r_match_size;
    t_phys r_window_low;
    t_phys r_window_high;

    // Sequencer and request registers.
    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_have, n_have;
    logic [IDX_W-1:0] r_fp, n_fp;
    logic             r_res, n_res;
    t_data            r_dest;
    t_data            r_size;
    t_data            r_off;
    logic             r_out_valid;
    logic             r_out_stream;

    // Tracker storage: hit counters in flops, the rest in memory.
    t_hits r_hits [ENTRIES];
    t_phys mem_dest [ENTRIES];
    t_data mem_size [ENTRIES];
    t_data mem_off  [ENTRIES];
    t_phys r_rd_dest;
    t_data r_rd_size;
    t_data r_rd_off;

    logic             w_all_en;
    logic             w_off_en;
    logic             hits_we;
    t_hits            hits_wdata;
    logic [IDX_W-1:0] w_addr;

    t_phys            phys;
    t_hits            cur_hits;
    t_hits            inc_hits;
    logic             ent_match;
    logic             cand;
    logic             in_xfer;
    logic             out_free;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign phys     = r_dest[PHYS_W-1:0];
    assign cur_hits = r_hits[r_idx];
    assign inc_hits = (cur_hits < HITS_MAX) ? cur_hits + 1'b1 : cur_hits;
    assign ent_match = (cur_hits != HITS_EMPTY) && (r_rd_dest == phys) && (r_rd_size == r_size);
    assign cand = !r_have && (cur_hits < HITS_MAX);
    assign w_addr = (r_state == S_FILL) ? r_slot : r_idx;

    // Sequencer: filter the request, scan one entry per cycle when it passes, fill on a miss.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_slot     = r_slot;
        n_have     = r_have;
        n_fp       = r_fp;
        n_res      = r_res;
        w_all_en   = 1'b0;
        w_off_en   = 1'b0;
        hits_we    = 1'b0;
        hits_wdata = inc_hits;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx  = '0;
                n_have = 1'b0;
                n_res  = 1'b0;
                if (r_dest[DATA_W-1:DATA_W-8] == 8'd0) begin
                    n_res   = r_low_dest;
                    n_state = S_DONE;
                end else if (r_size != r_match_size || phys < r_window_low ||
                             phys >= r_window_high) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (ent_match) begin
                    n_state = S_DONE;
                    if (r_rd_off == r_off) begin
                        n_res = 1'b0;
                    end else begin
                        w_off_en = 1'b1;
                        hits_we  = 1'b1;
                        n_res    = (inc_hits >= HITS_MAX);
                    end
                end else if (cur_hits == HITS_EMPTY) begin
                    n_slot  = r_idx;
                    n_state = S_FILL;
                end else begin
                    if (cand) begin
                        n_slot = r_idx;
                        n_have = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        // No free or young entry: take the round-robin victim.
                        if (!r_have && !cand) begin
                            n_slot = r_fp;
                            n_fp   = (r_fp == LAST_IDX) ? '0 : r_fp + 1'b1;
                        end
                        n_state = S_FILL;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FILL: begin
                w_all_en   = 1'b1;
                hits_we    = 1'b1;
                hits_wdata = HITS_ONE;
                n_res      = 1'b0;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_slot      <= '0;
            r_have      <= 1'b0;
            r_fp        <= '0;
            r_res       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_slot  <= n_slot;
            r_have  <= n_have;
            r_fp    <= n_fp;
            r_res   <= n_res;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result register.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dest <= i_dest_addr;
            r_size <= i_transfer_size;
            r_off  <= i_read_offset;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_stream <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_stream = r_out_stream;

    // Hit counters; zero marks an empty entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_hits[i] <= HITS_EMPTY;
            end
        end else if (hits_we) begin
            r_hits[w_addr] <= hits_wdata;
        end
    end

    // Tracker memory: one write port, one registered read port addressed ahead.
    always_ff @(posedge i_clk) begin
        if (w_all_en) begin
            mem_dest[w_addr] <= phys;
            mem_size[w_addr] <= r_size;
        end
        if (w_all_en || w_off_en) begin
            mem_off[w_addr] <= r_off;
        end
        r_rd_dest <= mem_dest[n_idx];
        r_rd_size <= mem_size[n_idx];
        r_rd_off  <= mem_off[n_idx];
    end

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_dest    <= RST_LOW_DEST;
            r_match_size  <= RST_MATCH_SIZE;
            r_window_low  <= RST_WINDOW_LOW;
            r_window_high <= RST_WINDOW_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOW_DEST:    r_low_dest    <= i_cfg_data[0];
                CFG_MATCH_SIZE:  r_match_size  <= i_cfg_data;
                CFG_WINDOW_LOW:  r_window_low  <= i_cfg_data[PHYS_W-1:0];
                CFG_WINDOW_HIGH: r_window_high <= i_cfg_data[PHYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // An accepted transfer always moves the sequencer into the check step.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CHECK))
        else $error("accepted transfer did not start a check");

    // A new result appears only out of the done step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");

    // The scan index and the fill slot stay inside the table.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_FILL) |-> (r_idx <= LAST_IDX && r_slot <= LAST_IDX))
        else $error("tracker index out of range");

endmodule
